>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/rmsc_pkg.sv
// ----------------------------------------------------------------------------
// rmsc_pkg
// Shared types, widths and the Liu-Layland bound generator for the
// rate-monotonic schedulability check.
// ----------------------------------------------------------------------------
package rmsc_pkg;

  localparam int PERIOD_W      = 16;
  localparam int EXEC_W        = 16;
  localparam int SUM_W         = 24;
  localparam int SLOT_OUT_W    = 3;
  localparam int RANK_OUT_W    = 4;
  localparam int DEF_MAX_TASKS = 8;
  localparam int DEF_FRAC_BITS = 16;
  localparam int ROOT_FRAC     = 30;
  localparam int ROOT_STEPS    = 32;
  localparam int MAX_TASK_LIM  = 32;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT
  } rmsc_state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Bound for k tasks: k*(2^(1/k)-1), root found by bisection in Q2.30,
  // power by repeated truncating multiplication. Evaluated at elaboration.
  function automatic logic [SUM_W-1:0] ll_bound(input int k, input int frac);
    longint unsigned one;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    longint unsigned b;
    bit              over;
    int              s;
    int              i;
    one = 64'd1 << ROOT_FRAC;
    lo  = one;
    hi  = one << 1;
    for (s = 0; s < ROOT_STEPS; s++) begin
      if (lo < hi) begin
        mid  = lo + ((hi - lo + 64'd1) >> 1);
        p    = one;
        over = 1'b0;
        for (i = 0; i < MAX_TASK_LIM; i++) begin
          if (i < k && !over) begin
            p = (p * mid) >> ROOT_FRAC;
            if (p > (one << 1)) over = 1'b1;
          end
        end
        if (p <= (one << 1)) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    b = (longint'(k) * (lo - one)) >> (ROOT_FRAC - frac);
    if (b > 64'(SUM_MAX)) b = 64'(SUM_MAX);
    return b[SUM_W-1:0];
  endfunction

endpackage

>>> sv/rmsc_divider.sv
// ----------------------------------------------------------------------------
// rmsc_divider
// Restoring radix-2 divider: one quotient bit per cycle. A zero divisor
// gives an all-ones quotient.
// ----------------------------------------------------------------------------
module rmsc_divider #(
  parameter int FRAC_BITS = rmsc_pkg::DEF_FRAC_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [rmsc_pkg::EXEC_W+FRAC_BITS-1:0]     dividend,
  input  logic [rmsc_pkg::PERIOD_W-1:0]             divisor,
  output logic [rmsc_pkg::EXEC_W+FRAC_BITS-1:0]     quotient,
  output rmsc_pkg::div_stat_t                       stat
);
  import rmsc_pkg::*;

  localparam int QW    = EXEC_W + FRAC_BITS;
  localparam int CNT_W = $clog2(QW + 1);

  logic [QW-1:0]       dvd;
  logic [QW-1:0]       quo;
  logic [PERIOD_W-1:0] dsr;
  logic [PERIOD_W-1:0] rem;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;

  logic [PERIOD_W:0]   rem_sh;
  logic [PERIOD_W+1:0] diff;
  logic                ge;

  // Trial subtraction of the shifted partial remainder
  always_comb begin
    rem_sh = {rem, dvd[QW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr};
    ge     = ~diff[PERIOD_W+1];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[QW-2:0], 1'b0};
      rem <= ge ? diff[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
      quo <= {quo[QW-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> sv/rate_monotonic_schedulability_check_core.sv
// ----------------------------------------------------------------------------
// rate_monotonic_schedulability_check_core
// Liu-Layland utilization test over a set of periodic tasks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one task per transfer:
//   period, execution time and a final-task flag. Output channel
//   (out_valid / out_stall) returns one result per task once a run closes,
//   in ascending period order (ties in arrival order).
//   For each task the serial divider yields one quotient bit per cycle,
//   and in_stall stays high until the term is summed.
//   A run closes on final_task or on the MAX_TASKS-th task. Then the
//   CHECK state tests the sum against the bound table, and each of the n
//   results takes a scan of the n stored periods before it is offered
//   on the output.
//   The block takes no new task until the last result has been transferred.
//   A stalled result holds until taken.
//   Reset (rst, synchronous) empties the task set and clears the sum.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rate_monotonic_schedulability_check_core #(
  parameter int MAX_TASKS = rmsc_pkg::DEF_MAX_TASKS,
  parameter int FRAC_BITS = rmsc_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rmsc_pkg::PERIOD_W-1:0]     task_period,
  input  logic [rmsc_pkg::EXEC_W-1:0]       task_exec_time,
  input  logic                              final_task,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rmsc_pkg::SLOT_OUT_W-1:0]   task_slot,
  output logic [rmsc_pkg::RANK_OUT_W-1:0]   priority_rank,
  output logic                              viable,
  output logic [rmsc_pkg::SUM_W-1:0]        utilization_q16,
  output logic                              last_result
);
  import rmsc_pkg::*;

  localparam int QW     = EXEC_W + FRAC_BITS;
  localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int KEY_W  = PERIOD_W + SLOT_W;

  rmsc_state_t state, state_next;

  // Bound table, one entry per task count
  logic [SUM_W-1:0] bound_rom [MAX_TASKS+1];
  assign bound_rom[0] = '0;
  for (genvar k = 1; k <= MAX_TASKS; k++) begin : g_bound
    localparam logic [SUM_W-1:0] BOUND = ll_bound(k, FRAC_BITS);
    assign bound_rom[k] = BOUND;
  end

  logic [PERIOD_W-1:0] period_store [MAX_TASKS];
  logic [CNT_W-1:0]    count;
  logic [SUM_W-1:0]    sum;
  logic                final_q;
  logic                viable_q;
  logic [SLOT_W-1:0]   scan_idx;
  logic [CNT_W-1:0]    rank;
  logic                first;
  logic                best_valid;
  logic [KEY_W-1:0]    best_key;
  logic [KEY_W-1:0]    prev_key;

  logic                in_xfer;
  logic                out_xfer;
  logic                div_start;
  logic [QW-1:0]       quotient;
  div_stat_t           div_stat;

  logic [CNT_W-1:0]    count_inc;
  logic                run_end;
  logic [QW:0]         sum_wide;
  logic [SUM_W-1:0]    sum_sat;
  logic [KEY_W-1:0]    cand_key;
  logic                take;
  logic                scan_last;
  logic                is_last;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // Shared divider: (exec << FRAC_BITS) / period
  rmsc_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({task_exec_time, {FRAC_BITS{1'b0}}}),
    .divisor  (task_period),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Saturating accumulate and run-close detection
  always_comb begin
    count_inc = count + 1'b1;
    run_end   = final_q || (count_inc == CNT_W'(MAX_TASKS));
    sum_wide  = {{(QW + 1 - SUM_W){1'b0}}, sum} + {1'b0, quotient};
    sum_sat   = (sum_wide > (QW + 1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
  end

  // Scan: next smallest (period, slot) key above the last one emitted
  always_comb begin
    cand_key  = {period_store[scan_idx], scan_idx};
    take      = (first || (cand_key > prev_key)) && (!best_valid || (cand_key < best_key));
    scan_last = ((CNT_W'(scan_idx) + 1'b1) == count);
    is_last   = (rank == count);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_xfer) state_next = ST_DIV;
      ST_DIV:   if (div_stat.done) state_next = ST_ACC;
      ST_ACC:   state_next = run_end ? ST_CHECK : ST_IDLE;
      ST_CHECK: state_next = ST_SCAN;
      ST_SCAN:  if (scan_last) state_next = ST_EMIT;
      ST_EMIT:  if (out_xfer) state_next = is_last ? ST_IDLE : ST_SCAN;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_EMIT);
    div_start = in_xfer;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      sum        <= '0;
      scan_idx   <= '0;
      rank       <= '0;
      first      <= 1'b1;
      best_valid <= 1'b0;
    end else begin
      case (state)
        ST_ACC: begin
          count <= count_inc;
          sum   <= sum_sat;
        end
        ST_CHECK: begin
          scan_idx   <= '0;
          rank       <= CNT_W'(1);
          first      <= 1'b1;
          best_valid <= 1'b0;
        end
        ST_SCAN: begin
          if (take) best_valid <= 1'b1;
          scan_idx <= scan_last ? '0 : scan_idx + 1'b1;
        end
        ST_EMIT: begin
          if (out_xfer) begin
            best_valid <= 1'b0;
            first      <= 1'b0;
            rank       <= rank + 1'b1;
            if (is_last) begin
              count <= '0;
              sum   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      period_store[count[SLOT_W-1:0]] <= task_period;
      final_q                         <= final_task;
    end
    if (state == ST_CHECK) viable_q <= (sum <= bound_rom[count]);
    if (state == ST_SCAN && take) best_key <= cand_key;
    if (out_xfer) prev_key <= best_key;
  end

  // Result fields, low bits of slot and rank
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;
  logic [CNT_W+RANK_OUT_W-1:0]  rank_ext;
  assign slot_ext        = {{SLOT_OUT_W{1'b0}}, best_key[SLOT_W-1:0]};
  assign rank_ext        = {{RANK_OUT_W{1'b0}}, rank};
  assign task_slot       = slot_ext[SLOT_OUT_W-1:0];
  assign priority_rank   = rank_ext[RANK_OUT_W-1:0];
  assign viable          = viable_q;
  assign utilization_q16 = sum;
  assign last_result     = is_last;

  // Checks
  `ASSERT_IMPL(a_no_accept_while_emit, clk, rst, !in_stall, !out_valid)
  `ASSERT_IMPL(a_div_only_in_div, clk, rst, div_stat.busy, state == ST_DIV)
  `ASSERT_IMPL(a_rank_in_run, clk, rst, out_valid, (rank != '0) && (rank <= count))
  `ASSERT_NEXT(a_run_closes, clk, rst, out_valid && last_result && !out_stall, !out_valid && (count == '0))

endmodule

>>> sim/rate_monotonic_schedulability_check_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rate_monotonic_schedulability_check_core_tb
// Self-checking bench for the Liu-Layland schedulability core. Task sets are
// pushed through the input channel. A local predictor sums utilization,
// checks it against its own bound table and orders the tasks by period.
// Every result transfer is compared against the oldest predicted result.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module rate_monotonic_schedulability_check_core_tb;
  import rmsc_pkg::*;

  localparam int NUM_SLOTS     = DEF_MAX_TASKS;
  localparam int Q_FRAC        = DEF_FRAC_BITS;
  localparam int STALL_PCT     = 15;
  localparam int WATCHDOG_LIM  = 4000;
  localparam int TAIL_CYCLES   = 200;
  localparam int RANDOM_ITEMS  = 250;

  typedef struct {
    logic [PERIOD_W-1:0] period;
    logic [EXEC_W-1:0]   exec_time;
    logic                last_task;
  } task_item_t;

  typedef struct {
    logic [SLOT_OUT_W-1:0] slot;
    logic [RANK_OUT_W-1:0] rank;
    logic                  fits;
    logic [SUM_W-1:0]      util;
    logic                  last;
  } sched_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PERIOD_W-1:0]   task_period = '0;
  logic [EXEC_W-1:0]     task_exec_time = '0;
  logic                  final_task = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SLOT_OUT_W-1:0] task_slot;
  logic [RANK_OUT_W-1:0] priority_rank;
  logic                  viable;
  logic [SUM_W-1:0]      utilization_q16;
  logic                  last_result;

  rate_monotonic_schedulability_check_core i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .task_period     (task_period),
    .task_exec_time  (task_exec_time),
    .final_task      (final_task),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .task_slot       (task_slot),
    .priority_rank   (priority_rank),
    .viable          (viable),
    .utilization_q16 (utilization_q16),
    .last_result     (last_result)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task_item_t    pending_tasks[$];
  sched_result_t expected_results[$];
  task_item_t    next_item;
  sched_result_t got;
  sched_result_t want;

  // Predictor state
  logic [SUM_W-1:0]    bound_q16 [1:NUM_SLOTS];
  logic [PERIOD_W-1:0] stored_period [0:NUM_SLOTS-1];
  int                  tasks_loaded;
  logic [SUM_W-1:0]    util_sum;

  int errors;
  int tasks_sent;
  int results_seen;
  int runs_closed;
  int runs_viable;
  int idle_cycles;

  // Liu-Layland bound for k tasks in Q8.16: bisect the Q2.30 k-th root of 2
  function automatic logic [SUM_W-1:0] liu_layland_q16(input int k);
    longint unsigned one;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    longint unsigned b;
    int              i;
    one = 64'd1 << 30;
    lo  = one;
    hi  = one << 1;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      p   = one;
      for (i = 0; i < k; i++) begin
        p = (p * mid) >> 30;
        if (p > (one << 1)) break;
      end
      if (p <= (one << 1)) lo = mid;
      else hi = mid - 64'd1;
    end
    b = (longint'(k) * (lo - one)) >> (30 - Q_FRAC);
    if (b > 64'hFF_FFFF) b = 64'hFF_FFFF;
    return b[SUM_W-1:0];
  endfunction

  // Accumulate one task; on run close, queue results in period order
  task automatic rank_and_check_task(input task_item_t t);
    longint unsigned term;
    longint unsigned sum;
    int              order [0:NUM_SLOTS-1];
    int              i;
    int              j;
    logic            fits;
    sched_result_t   r;
    if (tasks_loaded >= NUM_SLOTS) tasks_loaded = 0;
    stored_period[tasks_loaded] = t.period;
    if (t.period == 0) term = 64'hFF_FFFF;
    else term = (longint'(t.exec_time) << Q_FRAC) / longint'(t.period);
    sum = longint'(util_sum) + term;
    util_sum = (sum > 64'hFF_FFFF) ? SUM_MAX : sum[SUM_W-1:0];
    tasks_loaded++;
    if (!t.last_task && tasks_loaded < NUM_SLOTS) return;
    fits = (util_sum <= bound_q16[tasks_loaded]);
    // stable insertion sort by period
    for (i = 0; i < tasks_loaded; i++) begin
      j = i;
      while (j > 0 && stored_period[order[j-1]] > stored_period[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (i = 0; i < tasks_loaded; i++) begin
      r.slot = order[i][SLOT_OUT_W-1:0];
      r.rank = RANK_OUT_W'(i + 1);
      r.fits = fits;
      r.util = util_sum;
      r.last = (i + 1 == tasks_loaded);
      expected_results.push_back(r);
    end
    runs_closed++;
    if (fits) runs_viable++;
    tasks_loaded = 0;
    util_sum     = '0;
  endtask

  task automatic add_task(input int p, input int e, input bit last);
    task_item_t t;
    t.period    = p[PERIOD_W-1:0];
    t.exec_time = e[EXEC_W-1:0];
    t.last_task = last;
    pending_tasks.push_back(t);
  endtask

  // Random period: mostly full range, some short ones for ties, rare zero
  function automatic int pick_period();
    int sel;
    sel = $urandom_range(0, 49);
    if (sel == 0) return 0;
    if (sel < 15) return $urandom_range(1, 12);
    if (sel < 25) return $urandom_range(16'h8000, 16'hFFFF);
    return $urandom_range(1, 16'hFFFF);
  endfunction

  // Idle decision with a quiet window where the side never idles
  function automatic bit idle_now(input int count, input int lo, input int hi);
    if (count >= lo && count < hi) return 1'b0;
    return ($urandom_range(0, 99) < STALL_PCT);
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: result %0d %s mismatch: expected 0x%0h, actual 0x%0h",
               $time, results_seen, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Input driver: next task goes out once the current one has transferred
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        next_item.period    = task_period;
        next_item.exec_time = task_exec_time;
        next_item.last_task = final_task;
        rank_and_check_task(next_item);
        tasks_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_tasks.size() > 0 && !idle_now(tasks_sent, 100, 160)) begin
          next_item      = pending_tasks.pop_front();
          task_period    <= next_item.period;
          task_exec_time <= next_item.exec_time;
          final_task     <= next_item.last_task;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random back-pressure, compare each result transfer
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.slot = task_slot;
        got.rank = priority_rank;
        got.fits = viable;
        got.util = utilization_q16;
        got.last = last_result;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: slot %0d rank %0d viable %0b util 0x%0h last %0b",
                   $time, got.slot, got.rank, got.fits, got.util, got.last);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("task_slot", want.slot, got.slot);
          check_field("priority_rank", want.rank, got.rank);
          check_field("viable", want.fits, got.fits);
          check_field("utilization_q16", want.util, got.util);
          check_field("last_result", want.last, got.last);
        end
        results_seen++;
      end
      out_stall <= idle_now(results_seen, 100, 180);
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIM) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, expected_results.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int n;
    int k;
    int p;
    int e;
    bit last;
    errors       = 0;
    tasks_sent   = 0;
    results_seen = 0;
    runs_closed  = 0;
    runs_viable  = 0;
    idle_cycles  = 0;
    tasks_loaded = 0;
    util_sum     = '0;
    for (k = 1; k <= NUM_SLOTS; k++) bound_q16[k] = liu_layland_q16(k);

    // Directed: zero utilization, exactly 1.0 against the one-task bound,
    // exec far above period (saturates)
    add_task(1, 0, 1'b1);
    add_task(16'hFFFF, 16'hFFFF, 1'b1);
    add_task(1, 16'hFFFF, 1'b1);
    // zero period ranks first and saturates the sum
    add_task(3, 1, 1'b0);
    add_task(0, 5, 1'b1);
    // equal periods keep arrival order
    add_task(10, 1, 1'b0);
    add_task(5, 1, 1'b0);
    add_task(10, 1, 1'b0);
    add_task(5, 1, 1'b1);
    // full store closes the run without the final flag, descending periods
    for (k = 0; k < NUM_SLOTS; k++) add_task(16'hFFFF - k * 16'h1111, 16'h0800, 1'b0);
    // period bit extremes
    add_task(16'hFFFF, 16'h7FFF, 1'b0);
    add_task(16'h8000, 16'h0000, 1'b0);
    add_task(16'h0001, 16'h0000, 1'b1);

    // Random task sets, utilization mostly scaled to land near the bound
    k = 0;
    while (k < RANDOM_ITEMS) begin
      n = $urandom_range(1, NUM_SLOTS);
      for (int i = 0; i < n; i++) begin
        p = pick_period();
        if ($urandom_range(0, 9) < 3 || p == 0) e = $urandom_range(0, 16'hFFFF);
        else e = (p * $urandom_range(0, 300)) / (256 * n);
        last = (i == n - 1) && (n < NUM_SLOTS || $urandom_range(0, 1));
        add_task(p, e, last);
      end
      k += n;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_tasks.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d tasks in %0d runs (%0d within bound), %0d results checked",
             tasks_sent, runs_closed, runs_viable, results_seen);
    $display("Mismatches: %0d, results outstanding: %0d", errors, expected_results.size());
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
